// ===== rtl/nrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Non-restoring divider package
// Shared default width for the divider pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package nrd_pkg;

	// Default operand width of dividend, divisor, quotient and remainder.
	localparam int DEF_WIDTH = 16;

endpackage : nrd_pkg

`default_nettype wire

// ===== rtl/nrd_in_if.sv =====
// ----------------------------------------------------------------------------
// Divider request channel
// Valid/ready channel that carries one dividend and divisor per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrd_in_if #(
	parameter int WIDTH = nrd_pkg::DEF_WIDTH
) ();

	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] dividend;
	logic [WIDTH-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);

endinterface : nrd_in_if

`default_nettype wire

// ===== rtl/nrd_out_if.sv =====
// ----------------------------------------------------------------------------
// Divider result channel
// Valid/ready channel that carries one quotient, remainder and flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrd_out_if #(
	parameter int WIDTH = nrd_pkg::DEF_WIDTH
) ();

	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] quotient;
	logic [WIDTH-1:0] remainder;
	logic             divide_by_zero;

	modport source (output valid, output quotient, output remainder,
		output divide_by_zero, input ready);
	modport sink   (input valid, input quotient, input remainder,
		input divide_by_zero, output ready);

endinterface : nrd_out_if

`default_nettype wire

// ===== rtl/nonrestoring_divider.sv =====
// ----------------------------------------------------------------------------
// Unsigned non-restoring divider
// Divides a WIDTH-bit unsigned dividend by a WIDTH-bit unsigned divisor in a
// chain of WIDTH round cells plus one restoring stage.
//
//   channel  dir  fields                                   handshake
//   req      in   dividend, divisor                        valid/ready
//   rsp      out  quotient, remainder, divide_by_zero      valid/ready
//
// One request enters per cycle while the first cell can take it; each result
// passes through the cell chain, one cell per quotient bit, and then the final
// restoring stage. Each cell and the final stage is a register with its own
// valid bit, so bubbles close up and a stalled result does not block new
// requests until the whole chain is full. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module nonrestoring_divider #(
	parameter int WIDTH = nrd_pkg::DEF_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nrd_in_if.sink    req,
	nrd_out_if.source rsp
);

	import nrd_pkg::*;

	logic             vld_c [0:WIDTH];
	logic             rdy_c [0:WIDTH];
	logic [WIDTH:0]   rem_c [0:WIDTH];
	logic [WIDTH-1:0] quo_c [0:WIDTH];
	logic [WIDTH-1:0] dvs_c [0:WIDTH];

	// Feed the chain: remainder starts at zero, quotient holds the dividend
	assign vld_c[0]  = req.valid;
	assign req.ready = rdy_c[0];
	assign rem_c[0]  = '0;
	assign quo_c[0]  = req.dividend;
	assign dvs_c[0]  = req.divisor;

	// One cell per quotient bit
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		nrd_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_c[i]),
			.in_ready (rdy_c[i]),
			.in_rem   (rem_c[i]),
			.in_quo   (quo_c[i]),
			.in_dvs   (dvs_c[i]),
			.out_valid(vld_c[i+1]),
			.out_ready(rdy_c[i+1]),
			.out_rem  (rem_c[i+1]),
			.out_quo  (quo_c[i+1]),
			.out_dvs  (dvs_c[i+1])
		);
	end

	// Restore the remainder and hold the result
	nrd_fix #(
		.WIDTH(WIDTH)
	) u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_c[WIDTH]),
		.in_ready (rdy_c[WIDTH]),
		.in_rem   (rem_c[WIDTH]),
		.in_quo   (quo_c[WIDTH]),
		.in_dvs   (dvs_c[WIDTH]),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_quo  (rsp.quotient),
		.out_rem  (rsp.remainder),
		.out_dbz  (rsp.divide_by_zero)
	);

endmodule : nonrestoring_divider

`default_nettype wire

// ===== rtl/nrd_cell.sv =====
// ----------------------------------------------------------------------------
// Non-restoring divider cell
// One round of non-restoring division: shift the partial remainder and
// quotient left, add or subtract the divisor by the remainder sign, and
// register the result together with the divisor for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module nrd_cell #(
	parameter int WIDTH = nrd_pkg::DEF_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// upstream side
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH:0]   in_rem,
	input  wire logic [WIDTH-1:0] in_quo,
	input  wire logic [WIDTH-1:0] in_dvs,
	// downstream side
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH:0]        out_rem,
	output logic [WIDTH-1:0]      out_quo,
	output logic [WIDTH-1:0]      out_dvs
);

	import nrd_pkg::*;

	logic             valid_q;
	logic [WIDTH:0]   rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   addend;
	logic [WIDTH:0]   nxt_rem;
	logic [WIDTH-1:0] nxt_quo;
	logic             take;

	// Take a beat when this cell is empty or its content moves on
	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// Shift in the quotient top bit, then add or subtract the divisor
	always_comb begin
		shifted = {in_rem[WIDTH-1:0], in_quo[WIDTH-1]};
		addend  = {1'b0, in_dvs};
		if (in_rem[WIDTH]) begin
			nxt_rem = shifted + addend;
		end else begin
			nxt_rem = shifted - addend;
		end
		nxt_quo = {in_quo[WIDTH-2:0], ~nxt_rem[WIDTH]};
	end

	// Occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Load the round's result on a beat
	always_ff @(posedge clk) begin
		if (take) begin
			rem_q <= nxt_rem;
			quo_q <= nxt_quo;
			dvs_q <= in_dvs;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_quo   = quo_q;
	assign out_dvs   = dvs_q;

`ifndef NO_ASSERTIONS
	// A stalled cell keeps its content
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(rem_q) && $stable(quo_q)
			&& $stable(dvs_q))
		else $error("nrd_cell: stalled content changed");

	// The new quotient bit is the inverse of the remainder sign
	a_quo_bit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> quo_q[0] == !rem_q[WIDTH])
		else $error("nrd_cell: quotient bit does not match remainder sign");

	// The partial remainder stays within [-divisor, divisor)
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && dvs_q != '0 |->
			(rem_q[WIDTH] ? ((WIDTH+1)'(~rem_q + 1'b1) <= {1'b0, dvs_q})
				: (rem_q < {1'b0, dvs_q})))
		else $error("nrd_cell: partial remainder out of range");
`endif

endmodule : nrd_cell

`default_nettype wire

// ===== rtl/nrd_fix.sv =====
// ----------------------------------------------------------------------------
// Non-restoring divider final stage
// Restore a negative remainder by one addition of the divisor, flag a zero
// divisor, and hold the finished result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nrd_fix #(
	parameter int WIDTH = nrd_pkg::DEF_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// from the last cell
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH:0]   in_rem,
	input  wire logic [WIDTH-1:0] in_quo,
	input  wire logic [WIDTH-1:0] in_dvs,
	// result side
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_quo,
	output logic [WIDTH-1:0]      out_rem,
	output logic                  out_dbz
);

	import nrd_pkg::*;

	logic             valid_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic             dbz_q;

	logic [WIDTH-1:0] fixed_rem;
	logic             take;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// Add the divisor back once when the remainder ended negative
	always_comb begin
		if (in_rem[WIDTH]) begin
			fixed_rem = in_rem[WIDTH-1:0] + in_dvs;
		end else begin
			fixed_rem = in_rem[WIDTH-1:0];
		end
	end

	// Occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (take) begin
			quo_q <= in_quo;
			rem_q <= fixed_rem;
			dbz_q <= (in_dvs == '0);
		end
	end

	assign out_valid = valid_q;
	assign out_quo   = quo_q;
	assign out_rem   = rem_q;
	assign out_dbz   = dbz_q;

`ifndef NO_ASSERTIONS
	// A waiting result holds until taken
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(quo_q) && $stable(rem_q)
			&& $stable(dbz_q))
		else $error("nrd_fix: stalled result changed");

	// A zero divisor leaves an all-ones quotient
	a_dbz_quo: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && dbz_q |-> &quo_q)
		else $error("nrd_fix: zero divisor without all-ones quotient");

	// A new result only follows a beat from the last cell
	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(in_valid))
		else $error("nrd_fix: result appeared without an input beat");
`endif

endmodule : nrd_fix

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider pipeline testbench
// Sends dividend/divisor requests to the non-restoring divider: corner cases
// from a table, then random ones, with random source gaps and sink stalls in
// the first two phases and none in the last. Each result beat is checked in
// order against a queue of answers from the table or a software divider.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int W           = nrd_pkg::DEF_WIDTH;
	localparam int LATENCY     = W + 1;
	localparam int HANG_LIMIT  = 4000;
	localparam int N_DIRECTED  = 20;
	localparam int N_PER_PHASE = 177;

	typedef struct packed {
		logic [W-1:0] quotient;
		logic [W-1:0] remainder;
		logic         divide_by_zero;
	} quot_rem_t;

	typedef struct packed {
		logic [W-1:0] dividend;
		logic [W-1:0] divisor;
		logic         known;
		quot_rem_t    answer;
	} div_row_t;

	logic clk = 1'b0;
	logic arst_n;

	nrd_in_if  #(.WIDTH(W)) req_bus ();
	nrd_out_if #(.WIDTH(W)) rsp_bus ();

	nonrestoring_divider #(.WIDTH(W)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	quot_rem_t pending_results[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;

	// Corner cases; answers typed in only where they are obvious
	div_row_t corner_rows [N_DIRECTED] = '{
		'{16'h0000, 16'h0000, 1'b1, '{16'hFFFF, 16'h0000, 1'b1}},
		'{16'hFFFF, 16'h0000, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b1}},
		'{16'h1234, 16'h0000, 1'b1, '{16'hFFFF, 16'h1234, 1'b1}},
		'{16'h0000, 16'h0001, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
		'{16'hFFFF, 16'h0001, 1'b1, '{16'hFFFF, 16'h0000, 1'b0}},
		'{16'hFFFF, 16'hFFFF, 1'b1, '{16'h0001, 16'h0000, 1'b0}},
		'{16'h0001, 16'hFFFF, 1'b1, '{16'h0000, 16'h0001, 1'b0}},
		'{16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
		'{16'h8000, 16'hFFFF, 1'b1, '{16'h0000, 16'h8000, 1'b0}},
		'{16'hFFFF, 16'h8000, 1'b1, '{16'h0001, 16'h7FFF, 1'b0}},
		'{16'h7FFF, 16'h8000, 1'b1, '{16'h0000, 16'h7FFF, 1'b0}},
		'{16'h8000, 16'h8000, 1'b1, '{16'h0001, 16'h0000, 1'b0}},
		'{16'hFFFE, 16'h7FFF, 1'b1, '{16'h0002, 16'h0000, 1'b0}},
		'{16'hFFFF, 16'h0002, 1'b1, '{16'h7FFF, 16'h0001, 1'b0}},
		'{16'h5555, 16'hAAAA, 1'b0, '0},
		'{16'hAAAA, 16'h5555, 1'b0, '0},
		'{16'h0064, 16'h0007, 1'b0, '0},
		'{16'h0007, 16'h0064, 1'b0, '0},
		'{16'hFFFF, 16'h00FF, 1'b0, '0},
		'{16'hC350, 16'h0003, 1'b0, '0}
	};

	// Bit-level non-restoring division with a W+1 bit partial remainder
	function automatic quot_rem_t divide_nonrestoring(logic [W-1:0] dvd, logic [W-1:0] dvs);
		logic [W:0]   part;
		logic [W-1:0] quo;
		quot_rem_t    res;
		part = '0;
		quo  = dvd;
		for (int rnd = 0; rnd < W; rnd++) begin
			if (part[W]) begin
				part = {part[W-1:0], quo[W-1]} + {1'b0, dvs};
			end else begin
				part = {part[W-1:0], quo[W-1]} - {1'b0, dvs};
			end
			quo = {quo[W-2:0], ~part[W]};
		end
		// restore a negative final remainder
		if (part[W]) begin
			part = part + {1'b0, dvs};
		end
		res.quotient       = quo;
		res.remainder      = part[W-1:0];
		res.divide_by_zero = (dvs == '0);
		return res;
	endfunction

	// Clock
	always #1 clk = ~clk;

	// Present one request beat, hold it until taken, then log its answer
	task automatic issue_request(logic [W-1:0] dvd, logic [W-1:0] dvs, quot_rem_t answer);
		while ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.dividend <= dvd;
		req_bus.divisor  <= dvs;
		@(posedge clk);
		while (!req_bus.ready) begin
			@(posedge clk);
		end
		pending_results.push_back(answer);
	endtask

	// Hold off new requests until every result is back
	task automatic drain_results();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Pick operands from a mix of value classes
	task automatic pick_operands(output logic [W-1:0] dvd, output logic [W-1:0] dvs);
		dvd = W'($urandom);
		case ($urandom_range(9))
			0: dvs = '0;
			1: dvs = W'($urandom_range(1, 15));
			2: dvs = W'($urandom_range(1, 255));
			3: dvs = W'(1) << $urandom_range(W - 1);
			4: dvs = dvd + W'($urandom_range(2)) - W'(1);
			5: dvs = ~W'($urandom_range(3));
			default: dvs = W'($urandom);
		endcase
		case ($urandom_range(7))
			0: dvd = W'($urandom_range(255));
			1: dvd = ~W'($urandom_range(3));
			default: ;
		endcase
	endtask

	// Check result beats, drive sink stalls, and watch for a hang
	always @(posedge clk) begin
		quot_rem_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing outstanding: quotient %h remainder %h",
					rsp_bus.quotient, rsp_bus.remainder);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_bus.quotient !== want.quotient) begin
					$error("quotient: expected %h, got %h", want.quotient, rsp_bus.quotient);
					mismatches++;
				end
				if (rsp_bus.remainder !== want.remainder) begin
					$error("remainder: expected %h, got %h", want.remainder,
						rsp_bus.remainder);
					mismatches++;
				end
				if (rsp_bus.divide_by_zero !== want.divide_by_zero) begin
					$error("divide_by_zero: expected %b, got %b", want.divide_by_zero,
						rsp_bus.divide_by_zero);
					mismatches++;
				end
			end
		end
		rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);

		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Main sequence
	initial begin
		logic [W-1:0] dvd;
		logic [W-1:0] dvs;
		quot_rem_t    answer;

		arst_n           <= 1'b0;
		req_bus.valid    <= 1'b0;
		req_bus.dividend <= '0;
		req_bus.divisor  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			// set idling pattern: sender light, then receiver light, then none
			case (phase)
				0: begin src_idle_pct = 17; sink_stall_pct = 78; end
				1: begin src_idle_pct = 78; sink_stall_pct = 17; end
				default: begin src_idle_pct = 0; sink_stall_pct = 0; end
			endcase

			if (phase == 0) begin
				foreach (corner_rows[i]) begin
					answer = corner_rows[i].known ? corner_rows[i].answer :
						divide_nonrestoring(corner_rows[i].dividend, corner_rows[i].divisor);
					issue_request(corner_rows[i].dividend, corner_rows[i].divisor, answer);
				end
			end

			for (int n = 0; n < N_PER_PHASE; n++) begin
				pick_operands(dvd, dvs);
				issue_request(dvd, dvs, divide_nonrestoring(dvd, dvs));
				// pause mid-phase until the pipeline is empty
				if (n == N_PER_PHASE / 2) begin
					drain_results();
				end
			end
			drain_results();
		end

		// let any stray beat show up
		repeat (4 * LATENCY) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule : tb_top

// ===== nonrestoring_divider.f =====
rtl/nrd_pkg.sv
rtl/nrd_in_if.sv
rtl/nrd_out_if.sv
rtl/nrd_cell.sv
rtl/nrd_fix.sv
rtl/nonrestoring_divider.sv
verif/tb_top.sv
